FILE: sv/assert_macros.svh
// assertion helpers for the rtl, included by the page table manager core
// each macro expands to one labelled concurrent assertion on clk, disabled under rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tlpt_pkg.sv
// constants and types for the two-level page table manager
// no dependencies
package tlpt_pkg;

  // address split: directory index, table index, page offset
  localparam int IDX_W       = 10;
  localparam int OFF_W       = 12;
  localparam int VA_W        = 32;
  localparam int FRAME_W     = 20;
  localparam int DIR_SHIFT   = 22;
  localparam int DIR_ENTRIES = 1024;

  // page present bits are kept in 32-bit words, 32 words per table
  localparam int WORD_W          = 32;
  localparam int WSEL_W          = 5;
  localparam int WORDS_PER_TABLE = 32;
  localparam int PP_ROW_W        = IDX_W + WSEL_W;
  localparam int SLOT_W          = IDX_W + IDX_W;
  localparam int CNT_W           = 10;

  // request codes
  localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
  localparam logic [1:0] FUNC_MAP       = 2'd1;
  localparam logic [1:0] FUNC_UNMAP     = 2'd2;

  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } dir_entry_t;

endpackage

FILE: sv/two_level_page_table_manager_core.sv
// top level of the two-level page table manager: sequencer and table memories
// depends on tlpt_pkg and assert_macros.svh
//
// Usage:
//   Request channel in_valid / in_stall carries func, virt_addr, map_frame and
//   spare_frame; a beat is taken when in_valid is high and in_stall low.
//   Result channel out_valid / out_stall carries phys_addr, done_res,
//   table_freed and freed_frame; one result beat per request.
//   The block handles one request at a time and holds in_stall high until the
//   result beat has been taken.
//   A translate, a map into an existing table, a failed request or the unknown
//   code goes from the lookup state straight to the result beat; a map that
//   creates a table first clears each of the new table's 32 present words,
//   and an unmap of a present table first scans the table's present words,
//   one memory read per cycle.
//   The next request is taken no earlier than the cycle after the result beat.
//   After rst the directory memory is cleared one entry per cycle, a pass over
//   all 1024 entries during which in_stall stays high.
//   While out_stall is high the result beat holds and no request is taken.
module two_level_page_table_manager_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [tlpt_pkg::VA_W-1:0]    virt_addr,
  input  logic [tlpt_pkg::FRAME_W-1:0] map_frame,
  input  logic [tlpt_pkg::FRAME_W-1:0] spare_frame,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tlpt_pkg::VA_W-1:0]    phys_addr,
  output logic                        done_res,
  output logic                        table_freed,
  output logic [tlpt_pkg::FRAME_W-1:0] freed_frame
);

  `include "assert_macros.svh"

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic [tlpt_pkg::CNT_W-1:0] CNT_LAST_DIR =
    tlpt_pkg::CNT_W'(tlpt_pkg::DIR_ENTRIES - 1);
  localparam logic [tlpt_pkg::CNT_W-1:0] CNT_LAST_WORD =
    tlpt_pkg::CNT_W'(tlpt_pkg::WORDS_PER_TABLE - 1);
  localparam logic [tlpt_pkg::CNT_W-1:0] CNT_SCAN_END =
    tlpt_pkg::CNT_W'(tlpt_pkg::WORDS_PER_TABLE);

  // sequencer registers
  logic [2:0]                   state, state_next;
  logic [tlpt_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         nonempty, nonempty_next;

  // captured request
  logic [1:0]                   req_func;
  logic [tlpt_pkg::VA_W-1:0]    req_va;
  logic [tlpt_pkg::FRAME_W-1:0] req_map;
  logic [tlpt_pkg::FRAME_W-1:0] req_spare;

  // result registers
  logic [tlpt_pkg::VA_W-1:0]    phys_next;
  logic                         done_next, freed_next;
  logic [tlpt_pkg::FRAME_W-1:0] fframe_next;

  // memories
  tlpt_pkg::dir_entry_t         dir_mem [tlpt_pkg::DIR_ENTRIES];
  logic [tlpt_pkg::WORD_W-1:0]  pp_mem  [2**tlpt_pkg::PP_ROW_W];
  logic [tlpt_pkg::FRAME_W-1:0] pf_mem  [2**tlpt_pkg::SLOT_W];

  tlpt_pkg::dir_entry_t          dir_q, dir_wdata;
  logic [tlpt_pkg::IDX_W-1:0]    dir_raddr, dir_waddr;
  logic                          dir_we;
  logic [tlpt_pkg::WORD_W-1:0]   pp_q, pp_wdata;
  logic [tlpt_pkg::PP_ROW_W-1:0] pp_raddr, pp_waddr;
  logic                          pp_we;
  logic [tlpt_pkg::FRAME_W-1:0]  pf_q;
  logic [tlpt_pkg::SLOT_W-1:0]   pf_raddr;
  logic                          pf_we;

  // address fields
  logic                          accept;
  logic [tlpt_pkg::IDX_W-1:0]    req_dir, req_tbl, in_dir;
  logic [tlpt_pkg::IDX_W-1:0]    in_tbl;
  logic [tlpt_pkg::WSEL_W-1:0]   req_word;
  logic [tlpt_pkg::WORD_W-1:0]   bit_mask;
  logic                          page_hit;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  assign req_dir  = req_va[tlpt_pkg::VA_W-1 -: tlpt_pkg::IDX_W];
  assign req_tbl  = req_va[tlpt_pkg::OFF_W +: tlpt_pkg::IDX_W];
  assign req_word = req_tbl[tlpt_pkg::IDX_W-1 -: tlpt_pkg::WSEL_W];
  assign in_dir   = virt_addr[tlpt_pkg::VA_W-1 -: tlpt_pkg::IDX_W];
  assign in_tbl   = virt_addr[tlpt_pkg::OFF_W +: tlpt_pkg::IDX_W];
  assign bit_mask = {{(tlpt_pkg::WORD_W-1){1'b0}}, 1'b1} << req_tbl[tlpt_pkg::WSEL_W-1:0];
  assign page_hit = (pp_q & bit_mask) != '0;

  // read addresses: straight from the request beat while idle, else from the capture
  always_comb begin
    if (state == ST_IDLE) begin
      dir_raddr = in_dir;
      pp_raddr  = {in_dir, in_tbl[tlpt_pkg::IDX_W-1 -: tlpt_pkg::WSEL_W]};
      pf_raddr  = {in_dir, in_tbl};
    end else begin
      dir_raddr = req_dir;
      pf_raddr  = {req_dir, req_tbl};
      if (state == ST_SCAN) begin
        pp_raddr = {req_dir, cnt[tlpt_pkg::WSEL_W-1:0]};
      end else begin
        pp_raddr = {req_dir, req_word};
      end
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    nonempty_next = nonempty;
    phys_next     = phys_addr;
    done_next     = done_res;
    freed_next    = table_freed;
    fframe_next   = freed_frame;
    dir_we        = 1'b0;
    dir_waddr     = req_dir;
    dir_wdata     = '0;
    pp_we         = 1'b0;
    pp_waddr      = {req_dir, req_word};
    pp_wdata      = '0;
    pf_we         = 1'b0;
    case (state)
      // clearing pass over the directory after reset
      ST_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = cnt;
        if (cnt == CNT_LAST_DIR) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          phys_next   = '0;
          done_next   = 1'b0;
          freed_next  = 1'b0;
          fframe_next = '0;
          state_next  = ST_LOOK;
        end
      end
      // directory entry, present word and frame are on the read registers
      ST_LOOK: begin
        state_next = ST_OUT;
        case (req_func)
          tlpt_pkg::FUNC_TRANSLATE: begin
            if (dir_q.present && page_hit) begin
              phys_next = {pf_q, req_va[tlpt_pkg::OFF_W-1:0]};
              done_next = 1'b1;
            end
          end
          tlpt_pkg::FUNC_MAP: begin
            if (dir_q.present) begin
              if (!page_hit) begin
                pp_we     = 1'b1;
                pp_wdata  = pp_q | bit_mask;
                pf_we     = 1'b1;
                done_next = 1'b1;
              end
            end else if (req_spare != '0) begin
              // new table: claim the spare frame, then clear its present words
              dir_we          = 1'b1;
              dir_wdata.present = 1'b1;
              dir_wdata.frame = req_spare;
              pf_we           = 1'b1;
              done_next       = 1'b1;
              cnt_next        = '0;
              state_next      = ST_CLR;
            end
          end
          tlpt_pkg::FUNC_UNMAP: begin
            if (dir_q.present) begin
              pp_we         = 1'b1;
              pp_wdata      = pp_q & ~bit_mask;
              done_next     = 1'b1;
              cnt_next      = '0;
              nonempty_next = 1'b0;
              state_next    = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      // clear the new table, setting only the mapped page's bit
      ST_CLR: begin
        pp_we    = 1'b1;
        pp_waddr = {req_dir, cnt[tlpt_pkg::WSEL_W-1:0]};
        if (cnt[tlpt_pkg::WSEL_W-1:0] == req_word) begin
          pp_wdata = bit_mask;
        end
        if (cnt == CNT_LAST_WORD) begin
          state_next = ST_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      // read each present word; the read data arrives in the cycle after its address
      ST_SCAN: begin
        if (cnt != '0 && pp_q != '0) begin
          nonempty_next = 1'b1;
        end
        if (cnt == CNT_SCAN_END) begin
          if (!nonempty && pp_q == '0) begin
            dir_we          = 1'b1;
            dir_wdata.present = 1'b0;
            dir_wdata.frame = dir_q.frame;
            freed_next      = 1'b1;
            fframe_next     = dir_q.frame;
          end
          state_next = ST_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
        cnt_next   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      nonempty <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      nonempty <= nonempty_next;
    end
  end

  // request capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func;
      req_va    <= virt_addr;
      req_map   <= map_frame;
      req_spare <= spare_frame;
    end
    phys_addr   <= phys_next;
    done_res    <= done_next;
    table_freed <= freed_next;
    freed_frame <= fframe_next;
  end

  // directory memory
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_q <= dir_mem[dir_raddr];
  end

  // page present words
  always_ff @(posedge clk) begin
    if (pp_we) begin
      pp_mem[pp_waddr] <= pp_wdata;
    end
    pp_q <= pp_mem[pp_raddr];
  end

  // page frames
  always_ff @(posedge clk) begin
    if (pf_we) begin
      pf_mem[{req_dir, req_tbl}] <= req_map;
    end
    pf_q <= pf_mem[pf_raddr];
  end

  // checks
  `ASSERT_ALWAYS(a_no_take_while_result, !(out_valid && !in_stall),
                 "request taken while a result beat is pending")
  `ASSERT_ALWAYS(a_freed_implies_done, !(out_valid && table_freed) || done_res,
                 "table freed without a present directory entry")
  `ASSERT_ALWAYS(a_phys_translate_only,
                 !(out_valid && phys_addr != '0) || req_func == tlpt_pkg::FUNC_TRANSLATE,
                 "nonzero address on a request other than translate")
  `ASSERT_NEXT(a_clear_ends, state == ST_CLR && cnt == CNT_LAST_WORD, state == ST_OUT,
               "table clear did not finish after the last word")
  `ASSERT_NEXT(a_accept_looks, accept, state == ST_LOOK,
               "accepted request did not start a directory lookup")

endmodule

FILE: sim/two_level_page_table_manager_core_tb.sv
`timescale 1ns / 100ps
// self-checking bench for two_level_page_table_manager_core: translate, map, unmap and unknown-code beats
// depends on tlpt_pkg and the core rtl; expected results come from an in-bench table walker
module two_level_page_table_manager_core_tb;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int IDLE_PCT         = 24;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int TAIL_CYCLES      = 50;
  localparam int RANDOM_ITEMS     = 700;
  localparam int STEADY_ITEMS     = 110;
  localparam int HOLD_OFF_ITEMS   = 16;

  typedef struct packed {
    logic [tlpt_pkg::VA_W-1:0]    phys;
    logic                         done;
    logic                         freed;
    logic [tlpt_pkg::FRAME_W-1:0] fframe;
  } walk_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    func = tlpt_pkg::FUNC_TRANSLATE;
  logic [tlpt_pkg::VA_W-1:0]     virt_addr = '0;
  logic [tlpt_pkg::FRAME_W-1:0]  map_frame = '0;
  logic [tlpt_pkg::FRAME_W-1:0]  spare_frame = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [tlpt_pkg::VA_W-1:0]     phys_addr;
  logic                          done_res;
  logic                          table_freed;
  logic [tlpt_pkg::FRAME_W-1:0]  freed_frame;

  // shadow page tables
  bit                            dir_valid [tlpt_pkg::DIR_ENTRIES];
  logic [tlpt_pkg::FRAME_W-1:0]  dir_base  [tlpt_pkg::DIR_ENTRIES];
  bit [tlpt_pkg::DIR_ENTRIES-1:0] pte_valid [tlpt_pkg::DIR_ENTRIES];
  logic [tlpt_pkg::FRAME_W-1:0]  pte_frame [int unsigned];

  walk_result_t                  walk_results_q [$];
  int                            mismatches = 0;
  int                            quiet_cycles = 0;
  bit                            tx_idle_en = 1'b0;
  bit                            rx_idle_en = 1'b0;
  bit                            hold_off_req = 1'b0;
  logic [tlpt_pkg::IDX_W-1:0]    dir_pool [4];
  logic [tlpt_pkg::IDX_W-1:0]    tbl_pool [6];

  two_level_page_table_manager_core dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // apply one request to the shadow tables and return what the block must answer
  function automatic walk_result_t update_tables(
      input logic [1:0] op,
      input logic [tlpt_pkg::VA_W-1:0] va,
      input logic [tlpt_pkg::FRAME_W-1:0] mframe,
      input logic [tlpt_pkg::FRAME_W-1:0] spare);
    walk_result_t               r;
    logic [tlpt_pkg::IDX_W-1:0] d;
    logic [tlpt_pkg::IDX_W-1:0] t;
    int unsigned                slot;
    r = '0;
    d = va[tlpt_pkg::VA_W-1:tlpt_pkg::DIR_SHIFT];
    t = va[tlpt_pkg::DIR_SHIFT-1:tlpt_pkg::OFF_W];
    slot = 32'({d, t});
    case (op)
      tlpt_pkg::FUNC_TRANSLATE: begin
        if (dir_valid[d] && pte_valid[d][t]) begin
          r.phys = {pte_frame[slot], va[tlpt_pkg::OFF_W-1:0]};
          r.done = 1'b1;
        end
      end
      tlpt_pkg::FUNC_MAP: begin
        if (dir_valid[d]) begin
          if (!pte_valid[d][t]) begin
            pte_valid[d][t] = 1'b1;
            pte_frame[slot] = mframe;
            r.done = 1'b1;
          end
        end else if (spare != '0) begin
          // new table starts with every entry absent
          dir_valid[d] = 1'b1;
          dir_base[d] = spare;
          pte_valid[d] = '0;
          pte_valid[d][t] = 1'b1;
          pte_frame[slot] = mframe;
          r.done = 1'b1;
        end
      end
      tlpt_pkg::FUNC_UNMAP: begin
        if (dir_valid[d]) begin
          r.done = 1'b1;
          pte_valid[d][t] = 1'b0;
          // last entry gone: table released
          if (pte_valid[d] == '0) begin
            r.freed = 1'b1;
            r.fframe = dir_base[d];
            dir_valid[d] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string fname,
                                      input logic [tlpt_pkg::VA_W-1:0] want,
                                      input logic [tlpt_pkg::VA_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // result beats against the oldest expectation, plus the no-progress watchdog
  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (walk_results_q.size() == 0) begin
          $display("%0t result beat with nothing expected: phys %h done %b freed %b frame %h",
                   $time, phys_addr, done_res, table_freed, freed_frame);
          mismatches++;
        end else begin
          want = walk_results_q.pop_front();
          check_field("phys_addr", want.phys, phys_addr);
          check_field("done_res", 32'(want.done), 32'(done_res));
          check_field("table_freed", 32'(want.freed), 32'(table_freed));
          check_field("freed_frame", 32'(want.fframe), 32'(freed_frame));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results pending",
                 $time, quiet_cycles, walk_results_q.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result-side stall: random idling, or a long hold-off when asked
  initial begin : result_stall_driver
    int held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= rx_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // offer one request beat and hold it until taken
  task automatic send_request(input logic [1:0] op,
                              input logic [tlpt_pkg::VA_W-1:0] va,
                              input logic [tlpt_pkg::FRAME_W-1:0] mf,
                              input logic [tlpt_pkg::FRAME_W-1:0] sf);
    if (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    virt_addr   <= va;
    map_frame   <= mf;
    spare_frame <= sf;
    do @(posedge clk); while (in_stall);
    walk_results_q.push_back(update_tables(op, va, mf, sf));
  endtask

  // mostly pooled indices so tables fill up, hit and empty out; some stray addresses
  task automatic send_random_request();
    logic [1:0]                   op;
    logic [tlpt_pkg::IDX_W-1:0]   d;
    logic [tlpt_pkg::IDX_W-1:0]   t;
    logic [tlpt_pkg::OFF_W-1:0]   off;
    logic [tlpt_pkg::FRAME_W-1:0] sf;
    int                           pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = tlpt_pkg::FUNC_TRANSLATE;
    else if (pick < 68) op = tlpt_pkg::FUNC_MAP;
    else if (pick < 95) op = tlpt_pkg::FUNC_UNMAP;
    else op = FUNC_UNKNOWN;
    d = ($urandom_range(0, 99) < 85) ? dir_pool[$urandom_range(0, 3)]
                                     : tlpt_pkg::IDX_W'($urandom);
    t = ($urandom_range(0, 99) < 85) ? tbl_pool[$urandom_range(0, 5)]
                                     : tlpt_pkg::IDX_W'($urandom);
    off = tlpt_pkg::OFF_W'($urandom);
    sf = ($urandom_range(0, 9) == 0) ? '0 : tlpt_pkg::FRAME_W'($urandom);
    send_request(op, {d, t, off}, tlpt_pkg::FRAME_W'($urandom), sf);
  endtask

  // sender pauses until every result is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (walk_results_q.size() != 0);
  endtask

  function automatic logic [tlpt_pkg::VA_W-1:0] page_addr(input int d, input int t,
                                                          input int off);
    return {tlpt_pkg::IDX_W'(d), tlpt_pkg::IDX_W'(t), tlpt_pkg::OFF_W'(off)};
  endfunction

  // corner requests: empty tables, table creation and release, field extremes
  task automatic test_directed_cases();
    send_request(tlpt_pkg::FUNC_TRANSLATE, '0, '0, '0);
    send_request(tlpt_pkg::FUNC_TRANSLATE, '1, '1, '1);
    send_request(tlpt_pkg::FUNC_UNMAP, '1, '1, '1);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(0, 0, 0), 20'h12345, '0);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(0, 0, 0), '0, '1);
    send_request(tlpt_pkg::FUNC_TRANSLATE, page_addr(0, 0, 'hABC), '0, '0);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(0, 0, 0), 20'h54321, 20'h00077);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(1023, 1023, 0), '1, 20'h00001);
    send_request(tlpt_pkg::FUNC_TRANSLATE, '1, '0, '0);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(0, 1023, 0), 20'hA5A5A, '0);
    send_request(tlpt_pkg::FUNC_TRANSLATE, page_addr(0, 1023, 'hFFF), '0, '0);
    send_request(tlpt_pkg::FUNC_UNMAP, page_addr(0, 5, 0), '0, '0);
    send_request(tlpt_pkg::FUNC_UNMAP, page_addr(0, 0, 0), '0, '0);
    send_request(tlpt_pkg::FUNC_TRANSLATE, page_addr(0, 0, 1), '0, '0);
    send_request(tlpt_pkg::FUNC_UNMAP, page_addr(0, 1023, 0), '0, '0);
    send_request(tlpt_pkg::FUNC_TRANSLATE, page_addr(0, 1023, 0), '0, '0);
    send_request(FUNC_UNKNOWN, '1, '1, '1);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(5, 7, 0), 20'h5A5A5, 20'h0F0F0);
    send_request(tlpt_pkg::FUNC_UNMAP, page_addr(5, 7, 0), '0, '0);
    send_request(tlpt_pkg::FUNC_MAP, page_addr(5, 8, 0), 20'h00002, 20'hF0F0F);
    send_request(tlpt_pkg::FUNC_TRANSLATE, page_addr(5, 7, 0), '0, '0);
    send_request(tlpt_pkg::FUNC_TRANSLATE, page_addr(5, 8, 'h123), '0, '0);
    send_request(tlpt_pkg::FUNC_UNMAP, page_addr(5, 8, 0), '0, '0);
    send_request(tlpt_pkg::FUNC_UNMAP, '1, '0, '0);
    send_request(FUNC_UNKNOWN, '0, '0, '0);
  endtask

  // random mix with idling on both sides
  task automatic test_random_mix();
    int n;
    dir_pool = '{tlpt_pkg::IDX_W'(0), tlpt_pkg::IDX_W'(1023),
                 tlpt_pkg::IDX_W'($urandom), tlpt_pkg::IDX_W'($urandom)};
    tbl_pool = '{tlpt_pkg::IDX_W'(0), tlpt_pkg::IDX_W'(1023),
                 tlpt_pkg::IDX_W'($urandom), tlpt_pkg::IDX_W'($urandom),
                 tlpt_pkg::IDX_W'($urandom), tlpt_pkg::IDX_W'($urandom)};
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) send_random_request();
  endtask

  // back-to-back beats with no idling anywhere
  task automatic test_steady_stream();
    int n;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (n = 0; n < STEADY_ITEMS; n++) send_random_request();
  endtask

  // receiver holds off while requests keep coming, then the sender drains
  task automatic test_receiver_hold_off();
    int n;
    hold_off_req = 1'b1;
    for (n = 0; n < HOLD_OFF_ITEMS; n++) send_random_request();
    wait_all_results();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_mix();
    test_steady_stream();
    test_receiver_hold_off();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
